>>> sv/sidta_pkg.sv
// ----------------------------------------------------------------------------
// sidta_pkg
// Types and constants shared by the signed-integer-to-decimal-text blocks.
// ----------------------------------------------------------------------------
package sidta_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int STEP_W     = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

    localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(VALUE_W - 1);
    localparam logic [LEFT_W-1:0] LEFT_INIT  = LEFT_W'(NUM_DIGITS);
    localparam logic [LEFT_W-1:0] LEFT_FINAL = LEFT_W'(1);

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Result of a conversion handed from the converter to the character stage.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } sidta_bcd_t;

    typedef enum logic [1:0] {
        CVT_IDLE,
        CVT_SHIFT,
        CVT_DONE
    } sidta_cvt_state_t;

    typedef enum logic [1:0] {
        EMT_IDLE,
        EMT_SIGN,
        EMT_DIGIT
    } sidta_emt_state_t;

endpackage

>>> sv/sidta_dabble.sv
// ----------------------------------------------------------------------------
// sidta_dabble
// Bit-serial binary to BCD converter: shifts the magnitude in one bit a cycle
// through ten BCD digits, correcting each digit by add-3 before every shift.
// ----------------------------------------------------------------------------
module sidta_dabble
    import sidta_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      res_valid,
    input  logic                      res_ready,
    output sidta_bcd_t                res
);

    sidta_cvt_state_t    state_reg, state_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic                neg_reg, neg_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [VALUE_W-1:0]  value_bits;

    assign value_bits = value;

    // Digits of five or more gain three so that the following doubling carries.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CVT_IDLE:
                if (in_valid)
                    state_next = CVT_SHIFT;
            CVT_SHIFT:
                if (cnt_reg == STEP_LAST)
                    state_next = CVT_DONE;
            CVT_DONE:
                if (res_ready)
                    state_next = CVT_IDLE;
            default:
                state_next = CVT_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        case (state_reg)
            CVT_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    neg_next = value_bits[VALUE_W-1];
                    mag_next = value_bits[VALUE_W-1] ? (VALUE_W'(0) - value_bits)
                                                     : value_bits;
                    bcd_next = '0;
                    cnt_next = '0;
                end
            end
            CVT_SHIFT:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + STEP_W'(1);
            end
            CVT_DONE:
                res_valid = 1'b1;
            default:
                res_valid = 1'b0;
        endcase
    end

    assign res.neg = neg_reg;
    assign res.bcd = bcd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CVT_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
    end

endmodule

>>> sv/sidta_emit.sv
// ----------------------------------------------------------------------------
// sidta_emit
// Character stage: sends a minus sign for a negative value, then shifts the BCD
// digits out most significant first, skipping leading zeros, through an output register.
// ----------------------------------------------------------------------------
module sidta_emit
    import sidta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       res_valid,
    output logic       res_ready,
    input  sidta_bcd_t res,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] text_char,
    output logic       last
);

    sidta_emt_state_t  state_reg, state_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              started_reg, started_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;
    logic              slot_free;
    logic [3:0]        top_digit;
    logic              skip;
    logic              final_digit;

    assign slot_free   = !out_valid_reg || out_ready;
    assign top_digit   = bcd_reg[BCD_W-1 -: 4];
    assign final_digit = (left_reg == LEFT_FINAL);
    // A leading zero is dropped, but the units digit always goes out.
    assign skip        = (top_digit == 4'd0) && !started_reg && !final_digit;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EMT_IDLE:
                if (res_valid)
                    state_next = res.neg ? EMT_SIGN : EMT_DIGIT;
            EMT_SIGN:
                if (slot_free)
                    state_next = EMT_DIGIT;
            EMT_DIGIT:
                if (slot_free && final_digit)
                    state_next = EMT_IDLE;
            default:
                state_next = EMT_IDLE;
        endcase
    end

    always_comb
    begin
        res_ready      = 1'b0;
        bcd_next       = bcd_reg;
        left_next      = left_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        case (state_reg)
            EMT_IDLE:
            begin
                res_ready = 1'b1;
                if (res_valid)
                begin
                    bcd_next     = res.bcd;
                    left_next    = LEFT_INIT;
                    started_next = 1'b0;
                end
            end
            EMT_SIGN:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_MINUS;
                    last_next      = 1'b0;
                end
            EMT_DIGIT:
                if (skip)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    left_next = left_reg - LEFT_W'(1);
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_ZERO + {4'd0, top_digit};
                    last_next      = final_digit;
                    bcd_next       = {bcd_reg[BCD_W-5:0], 4'd0};
                    left_next      = left_reg - LEFT_W'(1);
                    started_next   = 1'b1;
                end
            default:
                res_ready = 1'b0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign text_char = char_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EMT_IDLE;
            left_reg      <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

>>> sv/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Converts a 32-bit two's complement integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, value) takes one integer per beat.
// The output channel (out_valid, out_ready, text_char, last) gives one ASCII
// character per beat: '-' for a negative value, then the digits most
// significant first with no leading zeros; last marks the final character.
// Zero gives the single character '0'.
// Conversion is bit-serial double dabble, one magnitude bit a cycle, so an
// integer occupies the converter through load, 32 shifts and hand-over,
// and in_ready is low meanwhile. The first character is registered after
// the hand-over and after the character stage has skipped any leading zeros
// of a positive value; the characters go out while the next conversion
// runs. A new integer is taken only once the converter has handed over the
// previous result.
// A stalled receiver holds the output register; the character stage waits,
// skipping only leading zeros; once it is full the converter holds its result.
// Reset empties every stage; nothing is kept between integers.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
    import sidta_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                text_char,
    output logic                      last
);

    sidta_bcd_t cvt_res;
    logic       cvt_valid;
    logic       cvt_ready;

    sidta_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .res_valid (cvt_valid),
        .res_ready (cvt_ready),
        .res       (cvt_res)
    );

    sidta_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (cvt_valid),
        .res_ready (cvt_ready),
        .res       (cvt_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last      (last)
    );

`ifndef SYNTHESIS
    // Only the sign and the ten digit characters ever leave the block.
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (text_char == ASCII_MINUS ||
                       (text_char >= ASCII_ZERO && text_char <= ASCII_NINE)))
        else $error("illegal character on output");

    // The sign is never the final character.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && text_char == ASCII_MINUS) |-> !last)
        else $error("sign character flagged as last");

    // The converter is busy for the cycle after it takes an integer.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while converter busy");

    // A finished conversion waits for the character stage unchanged.
    a_handoff_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cvt_valid && !cvt_ready) |=> (cvt_valid && $stable(cvt_res)))
        else $error("converter result dropped or changed while waiting");
`endif

endmodule
